### sv/dual_spring_damper_tracker_unit_macros.svh
// Assertion macros for the dual spring-damper tracker.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef DUAL_SPRING_DAMPER_TRACKER_UNIT_MACROS_SVH
`define DUAL_SPRING_DAMPER_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define DSDT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define DSDT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/dsdt_pkg.sv
// Shared types, widths and constants for the dual spring-damper tracker.
// No dependencies.
package dsdt_pkg;

	localparam int PX_W    = 8;
	localparam int SPD_W   = 10;
	localparam int COL_W   = 4;
	localparam int CIDX_W  = 3;
	localparam int POS_W   = 16;   // Q8.8 unsigned
	localparam int VEL_W   = 19;   // Q10.8 signed
	localparam int X_W     = 18;   // working position, signed
	localparam int DAMP_W  = 18;
	localparam int ACC_W   = 31;
	localparam int VT_W    = 26;
	localparam int MAG_W   = 37;
	localparam int QUO_W   = 29;
	localparam int RCP_W   = 30;
	localparam int MUL_W   = 31;
	localparam int PROD_W  = 2 * MUL_W;

	// Reciprocals ceil(2^K / d); exact floor division for dividends below 2^29.
	localparam logic [RCP_W-1:0] RECIP_5  = 30'd858993460;
	localparam logic [RCP_W-1:0] RECIP_10 = 30'd858993460;
	localparam logic [RCP_W-1:0] RECIP_30 = 30'd572662307;
	localparam int K_5  = 32;
	localparam int K_10 = 33;
	localparam int K_30 = 34;

	localparam int HALF_5    = 2;
	localparam int HALF_10   = 5;
	localparam int HALF_30   = 15;
	localparam int HALF_256  = 128;

	localparam int DAMP_EDGE = 2560;  // 10 px in Q8.8
	localparam int DAMP_RAMP = 28;

	localparam logic [2:0] COL_MAX  = 3'd7;
	localparam logic [2:0] COL_SPAN = 3'd5;

	localparam logic [PX_W-1:0]  RST_LEFT_LOW    = 8'd60;
	localparam logic [PX_W-1:0]  RST_LEFT_HIGH   = 8'd100;
	localparam logic [PX_W-1:0]  RST_RIGHT_LOW   = 8'd160;
	localparam logic [PX_W-1:0]  RST_RIGHT_HIGH  = 8'd200;
	localparam logic [PX_W-1:0]  RST_SPRING      = 8'd38;
	localparam logic [PX_W-1:0]  RST_BASE_DAMP   = 8'd8;
	localparam logic [PX_W-1:0]  RST_TREND       = 8'd32;
	localparam logic [SPD_W-1:0] RST_SPEED       = 10'd520;
	localparam logic [POS_W-1:0] RST_LEFT_CENTER  = 16'd20480;
	localparam logic [POS_W-1:0] RST_RIGHT_CENTER = 16'd46080;

	typedef logic signed [1:0] dir_t;
	localparam dir_t DIR_UP   = 2'sb01;
	localparam dir_t DIR_DOWN = 2'sb11;
	localparam dir_t DIR_NONE = 2'sb00;

	typedef enum logic [CIDX_W-1:0] {
		REG_LEFT_LOW,
		REG_LEFT_HIGH,
		REG_RIGHT_LOW,
		REG_RIGHT_HIGH,
		REG_SPRING_GAIN,
		REG_BASE_DAMPING,
		REG_TREND_GAIN,
		REG_SPEED_LIMIT
	} reg_idx_t;

	typedef struct packed {
		logic [PX_W-1:0]  spring;
		logic [PX_W-1:0]  base;
		logic [PX_W-1:0]  trend;
		logic [SPD_W-1:0] speed;
	} gain_t;

	typedef struct packed {
		logic [POS_W-1:0]        pos;
		logic signed [VEL_W-1:0] vel;
		logic [PX_W-1:0]         lo_px;
		logic [PX_W-1:0]         hi_px;
		logic [2:0]              m;
		dir_t                    dir;
	} trk_req_t;

	typedef struct packed {
		logic                    done;
		logic [POS_W-1:0]        pos;
		logic signed [VEL_W-1:0] vel;
	} trk_rsp_t;

	typedef enum logic [4:0] {
		C_IDLE,
		C_TGT_M,
		C_TGT_A,
		C_TGT_R,
		C_TGT_Q,
		C_DMP_A,
		C_DMP_R,
		C_DMP_Q,
		C_SPR,
		C_DMP_P,
		C_DMP_S,
		C_ACC_A,
		C_ACC_R,
		C_ACC_Q,
		C_VCLP,
		C_V_A,
		C_V_R,
		C_V_Q,
		C_CLMP,
		C_DONE
	} core_st_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_LGO,
		T_LRUN,
		T_RGO,
		T_RRUN,
		T_WB
	} top_st_t;

endpackage

### sv/dsdt_mul.sv
// Shared signed multiplier with a registered product.
// Depends on dsdt_pkg.
module dsdt_mul (
	input  logic                               clk,
	input  logic signed [dsdt_pkg::MUL_W-1:0]  a,
	input  logic signed [dsdt_pkg::MUL_W-1:0]  b,
	output logic signed [dsdt_pkg::PROD_W-1:0] p
);
	import dsdt_pkg::*;

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

### sv/dsdt_core.sv
// One track update (target, damping, forces, Euler steps, clamps) sequenced
// over the shared multiplier. Depends on dsdt_pkg and dsdt_mul.
module dsdt_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  dsdt_pkg::trk_req_t  req,
	input  dsdt_pkg::gain_t     gain,
	output dsdt_pkg::trk_rsp_t  rsp
);
	import dsdt_pkg::*;

	core_st_t st_q, st_d;

	logic signed [X_W-1:0]    lo_q, hi_q, x_q, tgt_q;
	logic signed [VEL_W-1:0]  v_q;
	logic [2:0]               m_q;
	dir_t                     dir_q;
	logic [DAMP_W-1:0]        damp_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [VT_W-1:0]   vt_q;
	logic [MAG_W-1:0]         mag_q;
	logic                     neg_q, near_q;

	logic signed [MUL_W-1:0]  ma, mb;
	logic signed [PROD_W-1:0] prod;

	logic [MAG_W-1:0]         prod_mag;
	logic [ACC_W-1:0]         acc_abs;
	logic [VEL_W-1:0]         v_abs;
	logic [QUO_W-1:0]         quo;
	logic signed [QUO_W:0]    sq;
	logic signed [X_W-1:0]    dl, dr, dmin, edge_gap;
	logic                     near;
	logic signed [ACC_W-1:0]  trend_term;
	logic signed [VT_W-1:0]   lim_v;
	logic signed [VEL_W-1:0]  vclamp;
	logic                     lo_hit, hi_hit;
	logic signed [X_W-1:0]    x1, x2;
	logic signed [VEL_W-1:0]  v1, v2;

	dsdt_mul u_mul (
		.clk (clk),
		.a   (ma),
		.b   (mb),
		.p   (prod)
	);

	// datapath helpers
	always_comb begin
		prod_mag = prod[PROD_W-1] ? MAG_W'(-prod) : MAG_W'(prod);
		acc_abs  = acc_q[ACC_W-1] ? -acc_q : acc_q;
		v_abs    = v_q[VEL_W-1] ? -v_q : v_q;

		case (st_q)
			C_TGT_Q: quo = prod[K_5+QUO_W-1:K_5];
			C_DMP_Q: quo = prod[K_10+QUO_W-1:K_10];
			default: quo = QUO_W'(prod[PROD_W-1:K_30]);
		endcase
		sq = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

		dl       = x_q - lo_q;
		dr       = hi_q - x_q;
		dmin     = (dl < dr) ? dl : dr;
		near     = dmin < X_W'(DAMP_EDGE);
		edge_gap = X_W'(DAMP_EDGE) - dmin;

		if (dir_q == DIR_UP) begin
			trend_term = ACC_W'($signed({1'b0, gain.trend, 8'b0}));
		end else if (dir_q == DIR_DOWN) begin
			trend_term = -ACC_W'($signed({1'b0, gain.trend, 8'b0}));
		end else begin
			trend_term = '0;
		end

		lim_v = VT_W'($signed({1'b0, gain.speed, 8'b0}));
		if (vt_q > lim_v) begin
			vclamp = VEL_W'(lim_v);
		end else if (vt_q < -lim_v) begin
			vclamp = VEL_W'(-lim_v);
		end else begin
			vclamp = VEL_W'(vt_q);
		end

		// low bound first, then high bound (order matters for reversed bounds)
		lo_hit = x_q < lo_q;
		x1     = lo_hit ? lo_q : x_q;
		v1     = (lo_hit && v_q[VEL_W-1]) ? '0 : v_q;
		hi_hit = x1 > hi_q;
		x2     = hi_hit ? hi_q : x1;
		v2     = (hi_hit && !v1[VEL_W-1] && (v1 != '0)) ? '0 : v1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// sequencer: next state, multiplier operands and response
	always_comb begin
		st_d     = st_q;
		ma       = '0;
		mb       = '0;
		rsp.done = 1'b0;
		rsp.pos  = x_q[POS_W-1:0];
		rsp.vel  = v_q;
		case (st_q)
			C_IDLE: begin
				if (start) st_d = C_TGT_M;
			end
			C_TGT_M: begin
				ma   = MUL_W'(hi_q - lo_q);
				mb   = MUL_W'($signed({1'b0, m_q}));
				st_d = C_TGT_A;
			end
			C_TGT_A: st_d = C_TGT_R;
			C_TGT_R: begin
				ma   = MUL_W'($signed({1'b0, mag_q[QUO_W-1:0]}));
				mb   = $signed({1'b0, RECIP_5});
				st_d = C_TGT_Q;
			end
			C_TGT_Q: begin
				ma   = near ? MUL_W'(edge_gap) : '0;
				mb   = MUL_W'(DAMP_RAMP);
				st_d = C_DMP_A;
			end
			C_DMP_A: st_d = C_DMP_R;
			C_DMP_R: begin
				ma   = MUL_W'($signed({1'b0, mag_q[QUO_W-1:0]}));
				mb   = $signed({1'b0, RECIP_10});
				st_d = C_DMP_Q;
			end
			C_DMP_Q: begin
				ma   = MUL_W'($signed({1'b0, gain.spring}));
				mb   = MUL_W'(tgt_q - x_q);
				st_d = C_SPR;
			end
			C_SPR: begin
				ma   = MUL_W'($signed({1'b0, damp_q}));
				mb   = MUL_W'(v_q);
				st_d = C_DMP_P;
			end
			C_DMP_P: st_d = C_DMP_S;
			C_DMP_S: st_d = C_ACC_A;
			C_ACC_A: st_d = C_ACC_R;
			C_ACC_R: begin
				ma   = MUL_W'($signed({1'b0, mag_q[QUO_W-1:0]}));
				mb   = $signed({1'b0, RECIP_30});
				st_d = C_ACC_Q;
			end
			C_ACC_Q: st_d = C_VCLP;
			C_VCLP:  st_d = C_V_A;
			C_V_A:   st_d = C_V_R;
			C_V_R: begin
				ma   = MUL_W'($signed({1'b0, mag_q[QUO_W-1:0]}));
				mb   = $signed({1'b0, RECIP_30});
				st_d = C_V_Q;
			end
			C_V_Q:   st_d = C_CLMP;
			C_CLMP:  st_d = C_DONE;
			C_DONE: begin
				rsp.done = 1'b1;
				st_d     = C_IDLE;
			end
			default: st_d = C_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			C_IDLE: begin
				if (start) begin
					lo_q  <= $signed({2'b00, req.lo_px, 8'b0});
					hi_q  <= $signed({2'b00, req.hi_px, 8'b0});
					x_q   <= $signed({2'b00, req.pos});
					v_q   <= req.vel;
					m_q   <= req.m;
					dir_q <= req.dir;
				end
			end
			C_TGT_A: begin
				mag_q <= prod_mag + MAG_W'(HALF_5);
				neg_q <= prod[PROD_W-1];
			end
			C_TGT_Q: begin
				tgt_q  <= lo_q + X_W'(sq);
				near_q <= near;
			end
			C_DMP_A: begin
				mag_q <= prod_mag + MAG_W'(HALF_10);
				neg_q <= 1'b0;
			end
			C_DMP_Q: begin
				damp_q <= DAMP_W'({gain.base, 8'b0}) + (near_q ? DAMP_W'(quo) : '0);
			end
			C_SPR: begin
				acc_q <= ACC_W'(prod) + trend_term;
			end
			C_DMP_P: begin
				mag_q <= prod_mag + MAG_W'(HALF_256);
				neg_q <= prod[PROD_W-1];
			end
			C_DMP_S: begin
				// subtract the rounded damping force
				if (neg_q) begin
					acc_q <= acc_q + $signed(ACC_W'(mag_q[MAG_W-1:8]));
				end else begin
					acc_q <= acc_q - $signed(ACC_W'(mag_q[MAG_W-1:8]));
				end
			end
			C_ACC_A: begin
				mag_q <= MAG_W'(acc_abs) + MAG_W'(HALF_30);
				neg_q <= acc_q[ACC_W-1];
			end
			C_ACC_Q: begin
				vt_q <= VT_W'(v_q) + VT_W'(sq);
			end
			C_VCLP: begin
				v_q <= vclamp;
			end
			C_V_A: begin
				mag_q <= MAG_W'(v_abs) + MAG_W'(HALF_30);
				neg_q <= v_q[VEL_W-1];
			end
			C_V_Q: begin
				x_q <= x_q + X_W'(sq);
			end
			C_CLMP: begin
				x_q <= x2;
				v_q <= v2;
			end
			default: ;
		endcase
	end

endmodule

### sv/dual_spring_damper_tracker_unit.sv
// Top level of the dual spring-damper tracker: config registers, track
// state, handshakes and draw logic. Depends on dsdt_pkg and dsdt_core.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index[2:0], cfg_data[9:0]
//  in      | in        | in_valid / in_ready   | finger_column[3:0], restart
//  out     | out       | out_valid / out_ready | left/right_pixel, redraw, erase_old,
//          |           |                       | old_left/right_pixel
//
// After acceptance a request runs, per track, through a start state, 18
// steps on the single shared multiplier and a done state, first for the
// left track and then for the right, then a write-back state that loads
// the result into the output register. in_ready is high only when idle.
// A finished result waits in the output register; the next request can be
// accepted while it waits, and write-back stalls only if it is still unread.
// Reset loads the register defaults, centers both tracks and arms a restart
// for the first request. cfg_ready is always high.
module dual_spring_damper_tracker_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dsdt_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [dsdt_pkg::SPD_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dsdt_pkg::COL_W-1:0]    finger_column,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dsdt_pkg::PX_W-1:0]     left_pixel,
	output logic [dsdt_pkg::PX_W-1:0]     right_pixel,
	output logic                          redraw,
	output logic                          erase_old,
	output logic [dsdt_pkg::PX_W-1:0]     old_left_pixel,
	output logic [dsdt_pkg::PX_W-1:0]     old_right_pixel
);
	import dsdt_pkg::*;

	// configuration
	logic [PX_W-1:0]  left_low_q, left_high_q, right_low_q, right_high_q;
	logic [PX_W-1:0]  spring_q, base_q, trend_q;
	logic [SPD_W-1:0] speed_q;

	// track state
	logic [POS_W-1:0]        lpos_q, rpos_q;
	logic signed [VEL_W-1:0] lvel_q, rvel_q;
	logic [2:0]              last_q;
	logic                    start_q;
	logic [PX_W-1:0]         drawn_l_q, drawn_r_q;
	logic                    dv_q;

	// per-request values
	logic [2:0] m_q;
	dir_t       dir_q;

	// output register
	logic            out_valid_q;
	logic [PX_W-1:0] lp_q, rp_q, old_l_q, old_r_q;
	logic            redraw_q, erase_q;

	top_st_t  tst_q, tst_d;
	logic     in_fire, core_start, load;
	trk_req_t req;
	trk_rsp_t rsp;
	gain_t    gain;

	logic [2:0]       col, prev_col;
	logic             eff_rst;
	dir_t             dir_new;
	logic [POS_W:0]   lsum, rsum;
	logic [PX_W-1:0]  lp, rp;
	logic             redraw_n, erase_n;

	assign cfg_ready = 1'b1;
	assign in_ready  = (tst_q == T_IDLE);
	assign in_fire   = in_valid && in_ready;

	assign gain.spring = spring_q;
	assign gain.base   = base_q;
	assign gain.trend  = trend_q;
	assign gain.speed  = speed_q;

	dsdt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (core_start),
		.req    (req),
		.gain   (gain),
		.rsp    (rsp)
	);

	// column saturation, restart handling and trend direction
	always_comb begin
		col      = (finger_column > COL_W'(COL_MAX)) ? COL_MAX : finger_column[2:0];
		eff_rst  = restart || start_q;
		prev_col = eff_rst ? col : last_q;
		if (col > prev_col) begin
			dir_new = DIR_UP;
		end else if (col < prev_col) begin
			dir_new = DIR_DOWN;
		end else begin
			dir_new = DIR_NONE;
		end
	end

	// rounding to pixels and draw decision
	always_comb begin
		lsum     = {1'b0, lpos_q} + (POS_W+1)'(HALF_256);
		rsum     = {1'b0, rpos_q} + (POS_W+1)'(HALF_256);
		lp       = lsum[POS_W-1:8];
		rp       = rsum[POS_W-1:8];
		redraw_n = !dv_q || (lp != drawn_l_q) || (rp != drawn_r_q);
		erase_n  = redraw_n && dv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tst_q <= T_IDLE;
		end else begin
			tst_q <= tst_d;
		end
	end

	// sequencer over the two tracks
	always_comb begin
		tst_d      = tst_q;
		core_start = 1'b0;
		load       = 1'b0;
		req.pos    = lpos_q;
		req.vel    = lvel_q;
		req.lo_px  = left_low_q;
		req.hi_px  = left_high_q;
		req.m      = m_q;
		req.dir    = dir_q;
		case (tst_q)
			T_IDLE: begin
				if (in_fire) tst_d = T_LGO;
			end
			T_LGO: begin
				core_start = 1'b1;
				tst_d      = T_LRUN;
			end
			T_LRUN: begin
				if (rsp.done) tst_d = T_RGO;
			end
			T_RGO: begin
				core_start = 1'b1;
				req.pos    = rpos_q;
				req.vel    = rvel_q;
				req.lo_px  = right_low_q;
				req.hi_px  = right_high_q;
				tst_d      = T_RRUN;
			end
			T_RRUN: begin
				if (rsp.done) tst_d = T_WB;
			end
			T_WB: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					load  = 1'b1;
					tst_d = T_IDLE;
				end
			end
			default: tst_d = T_IDLE;
		endcase
	end

	// config register writes; all eight indexes name a register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_low_q   <= RST_LEFT_LOW;
			left_high_q  <= RST_LEFT_HIGH;
			right_low_q  <= RST_RIGHT_LOW;
			right_high_q <= RST_RIGHT_HIGH;
			spring_q     <= RST_SPRING;
			base_q       <= RST_BASE_DAMP;
			trend_q      <= RST_TREND;
			speed_q      <= RST_SPEED;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_LEFT_LOW:     left_low_q   <= cfg_data[PX_W-1:0];
				REG_LEFT_HIGH:    left_high_q  <= cfg_data[PX_W-1:0];
				REG_RIGHT_LOW:    right_low_q  <= cfg_data[PX_W-1:0];
				REG_RIGHT_HIGH:   right_high_q <= cfg_data[PX_W-1:0];
				REG_SPRING_GAIN:  spring_q     <= cfg_data[PX_W-1:0];
				REG_BASE_DAMPING: base_q       <= cfg_data[PX_W-1:0];
				REG_TREND_GAIN:   trend_q      <= cfg_data[PX_W-1:0];
				REG_SPEED_LIMIT:  speed_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// track state: restart on accept, core results, draw bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpos_q    <= RST_LEFT_CENTER;
			rpos_q    <= RST_RIGHT_CENTER;
			lvel_q    <= '0;
			rvel_q    <= '0;
			last_q    <= '0;
			start_q   <= 1'b1;
			drawn_l_q <= '0;
			drawn_r_q <= '0;
			dv_q      <= 1'b0;
		end else begin
			if (in_fire) begin
				last_q  <= col;
				start_q <= 1'b0;
				if (eff_rst) begin
					// center = (low + high) * 128 in Q8.8
					lpos_q <= {({1'b0, left_low_q} + {1'b0, left_high_q}), 7'b0};
					rpos_q <= {({1'b0, right_low_q} + {1'b0, right_high_q}), 7'b0};
					lvel_q <= '0;
					rvel_q <= '0;
					dv_q   <= 1'b0;
				end
			end
			if (tst_q == T_LRUN && rsp.done) begin
				lpos_q <= rsp.pos;
				lvel_q <= rsp.vel;
			end
			if (tst_q == T_RRUN && rsp.done) begin
				rpos_q <= rsp.pos;
				rvel_q <= rsp.vel;
			end
			if (load && redraw_n) begin
				drawn_l_q <= lp;
				drawn_r_q <= rp;
				dv_q      <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			m_q   <= (col > COL_SPAN) ? COL_SPAN : col;
			dir_q <= dir_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lp_q     <= lp;
			rp_q     <= rp;
			redraw_q <= redraw_n;
			erase_q  <= erase_n;
			old_l_q  <= erase_n ? drawn_l_q : '0;
			old_r_q  <= erase_n ? drawn_r_q : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign left_pixel      = lp_q;
	assign right_pixel     = rp_q;
	assign redraw          = redraw_q;
	assign erase_old       = erase_q;
	assign old_left_pixel  = old_l_q;
	assign old_right_pixel = old_r_q;

endmodule

### sv/dsdt_checker.sv
// Port-level checks for the dual spring-damper tracker, bound to the top.
// Depends on the assertion macro header.
`include "dual_spring_damper_tracker_unit_macros.svh"

module dsdt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic [2:0] cfg_index,
	input logic [9:0] cfg_data,
	input logic       in_valid,
	input logic       in_ready,
	input logic [3:0] finger_column,
	input logic       restart,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] left_pixel,
	input logic [7:0] right_pixel,
	input logic       redraw,
	input logic       erase_old,
	input logic [7:0] old_left_pixel,
	input logic [7:0] old_right_pixel
);

	// erase only ever accompanies a redraw
	`DSDT_ASSERT_NOW(a_erase_needs_redraw, out_valid && erase_old, redraw,
		"erase_old without redraw")

	// without an erase the old positions read as zero
	`DSDT_ASSERT_NOW(a_old_zero, out_valid && !erase_old,
		(old_left_pixel == 8'd0) && (old_right_pixel == 8'd0),
		"old pixels nonzero without erase_old")

	// one request at a time: busy right after an accept
	`DSDT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
		"in_ready high right after an accepted request")

	// a stalled result holds
	`DSDT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(left_pixel) && $stable(right_pixel) && $stable(redraw) && $stable(erase_old),
		"stalled result changed")

endmodule

bind dual_spring_damper_tracker_unit dsdt_checker u_dsdt_checker (.*);
